// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define SPSC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked assertion that is also checked during reset.
`define SPSC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// File: hw/rtl/spsc_pkg.sv
// Package: shared constants and types of the stack pop sequence checker.
`timescale 1ns / 1ps
package spsc_pkg;

    // Width of a stack value and of the configuration registers
    localparam int SPSC_VAL_W = 11;
    // Operand width of the shared compare/subtract unit
    localparam int SPSC_AW = 18;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_CAPACITY = 1024;
    localparam int DEF_MAX_LENGTH   = 1024;

    // Register reset values
    localparam logic [SPSC_VAL_W-1:0] CAPACITY_RST   = 11'd5;
    localparam logic [SPSC_VAL_W-1:0] SEQ_LENGTH_RST = 11'd7;

    // Register indexes (word address bit 2)
    localparam logic REG_CAPACITY   = 1'b0;
    localparam logic REG_SEQ_LENGTH = 1'b1;

    // Result of the shared compare/subtract unit (a - b)
    typedef struct packed {
        logic              lt;
        logic              eq;
        logic              gt;
        logic [SPSC_AW-1:0] diff;
    } t_alu_res;

endpackage

// File: hw/rtl/stack_pop_sequence_checker.sv
// Top level: register port and checker core of the stack pop sequence checker.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------
//  input   | in        | i_in_valid / o_in_stall    | i_pop_value
//  output  | out       | o_out_valid / i_out_stall  | o_sequence_ok
//  config  | in        | psel / penable / pready    | paddr, pwdata
//
// A beat goes from idle through the range check, the top compare, the popped-before
// check, the room check and the push loop to the done step; a check that settles
// the beat jumps there, and after a failure every beat goes there from idle. The
// push loop writes one stack entry per cycle through the single RAM write port.
// A stalled verdict holds the last beat of a sequence in its final step.
// Reset is synchronous, active low; the stack store itself is not cleared.
`timescale 1ns / 1ps
module stack_pop_sequence_checker #(
    parameter int MAX_CAPACITY = spsc_pkg::DEF_MAX_CAPACITY,
    parameter int MAX_LENGTH   = spsc_pkg::DEF_MAX_LENGTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            i_in_valid,
    input  logic [spsc_pkg::SPSC_VAL_W-1:0] i_pop_value,
    output logic                            o_in_stall,
    output logic                            o_out_valid,
    output logic                            o_sequence_ok,
    input  logic                            i_out_stall
);
    import spsc_pkg::*;

    logic [SPSC_VAL_W-1:0] r_capacity;
    logic [SPSC_VAL_W-1:0] r_seq_length;
    logic                  wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity   <= CAPACITY_RST;
            r_seq_length <= SEQ_LENGTH_RST;
        end else if (wr_en) begin
            case (paddr[2])
                REG_CAPACITY:   r_capacity   <= pwdata[SPSC_VAL_W-1:0];
                REG_SEQ_LENGTH: r_seq_length <= pwdata[SPSC_VAL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read back
    always_comb begin
        case (paddr[2])
            REG_CAPACITY:   prdata = 32'(r_capacity);
            REG_SEQ_LENGTH: prdata = 32'(r_seq_length);
            default:        prdata = '0;
        endcase
    end

    spsc_core #(
        .MAX_CAPACITY (MAX_CAPACITY),
        .MAX_LENGTH   (MAX_LENGTH)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_capacity    (r_capacity),
        .i_seq_length  (r_seq_length),
        .i_in_valid    (i_in_valid),
        .i_pop_value   (i_pop_value),
        .o_in_stall    (o_in_stall),
        .o_out_valid   (o_out_valid),
        .o_sequence_ok (o_sequence_ok),
        .i_out_stall   (i_out_stall)
    );

endmodule

// File: hw/rtl/spsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module spsc_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/spsc_alu.sv
// Shared compare/subtract unit used by every check of the sequencer.
`timescale 1ns / 1ps
module spsc_alu (
    input  logic [spsc_pkg::SPSC_AW-1:0] i_a,
    input  logic [spsc_pkg::SPSC_AW-1:0] i_b,
    output spsc_pkg::t_alu_res           o_res
);
    import spsc_pkg::*;

    logic [SPSC_AW:0] diff;

    // One subtractor; borrow gives less-than
    always_comb begin
        diff       = {1'b0, i_a} - {1'b0, i_b};
        o_res.lt   = diff[SPSC_AW];
        o_res.eq   = (i_a == i_b);
        o_res.gt   = !diff[SPSC_AW] && (i_a != i_b);
        o_res.diff = diff[SPSC_AW-1:0];
    end

endmodule

// File: hw/rtl/spsc_core.sv
// Sequencer, stack bookkeeping and result register of the pop sequence checker.
`timescale 1ns / 1ps
module spsc_core #(
    parameter int MAX_CAPACITY = spsc_pkg::DEF_MAX_CAPACITY,
    parameter int MAX_LENGTH   = spsc_pkg::DEF_MAX_LENGTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [spsc_pkg::SPSC_VAL_W-1:0] i_capacity,
    input  logic [spsc_pkg::SPSC_VAL_W-1:0] i_seq_length,
    input  logic                            i_in_valid,
    input  logic [spsc_pkg::SPSC_VAL_W-1:0] i_pop_value,
    output logic                            o_in_stall,
    output logic                            o_out_valid,
    output logic                            o_sequence_ok,
    input  logic                            i_out_stall
);
    import spsc_pkg::*;

    localparam int DEPTH_W = $clog2(MAX_CAPACITY + 1);
    localparam int CNT_W   = $clog2(MAX_LENGTH + 1);
    localparam int ADDR_W  = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1;
    localparam int NEXT_W  = SPSC_VAL_W + 1;
    localparam logic [SPSC_AW-1:0] MAXC = SPSC_AW'(MAX_CAPACITY);
    localparam logic [SPSC_AW-1:0] MAXL = SPSC_AW'(MAX_LENGTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RNG,
        S_TOP,
        S_NXT,
        S_CAP,
        S_PUSH,
        S_DONE
    } t_state;

    t_state                r_state,  n_state;
    logic [SPSC_VAL_W-1:0] r_val,    n_val;
    logic [SPSC_VAL_W-1:0] r_len,    n_len;
    logic [SPSC_VAL_W-1:0] r_cap,    n_cap;
    logic [SPSC_VAL_W-1:0] r_diff,   n_diff;
    logic [DEPTH_W-1:0]    r_depth,  n_depth;
    logic [NEXT_W-1:0]     r_next,   n_next;
    logic [CNT_W-1:0]      r_cnt,    n_cnt;
    logic                  r_failed, n_failed;
    logic                  r_ov,     n_ov;
    logic                  r_ok,     n_ok;

    logic [SPSC_AW-1:0]    alu_a, alu_b;
    t_alu_res              alu_res;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [DEPTH_W-1:0]    depth_m1;
    logic [SPSC_VAL_W-1:0] top_val;
    logic [SPSC_AW-1:0]    cap_w, len_w;
    logic                  out_free;
    logic                  last_item;

    // Stack storage
    spsc_ram #(
        .WIDTH (SPSC_VAL_W),
        .DEPTH (MAX_CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_depth[ADDR_W-1:0]),
        .i_wdata (r_next[SPSC_VAL_W-1:0]),
        .i_raddr (ram_raddr),
        .o_rdata (top_val)
    );

    // Top-of-stack address follows the depth at all times
    assign depth_m1  = r_depth - DEPTH_W'(1);
    assign ram_raddr = depth_m1[ADDR_W-1:0];

    spsc_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    assign cap_w     = SPSC_AW'(i_capacity);
    assign len_w     = SPSC_AW'(i_seq_length);
    assign out_free  = !r_ov || !i_out_stall;
    assign last_item = (SPSC_AW'(r_cnt) + SPSC_AW'(1)) >= SPSC_AW'(r_len);

    // Operand selection for the shared unit
    always_comb begin
        alu_a = '0;
        alu_b = '0;
        case (r_state)
            S_RNG: begin
                alu_a = SPSC_AW'(r_len);
                alu_b = SPSC_AW'(r_val);
            end
            S_TOP: begin
                alu_a = SPSC_AW'(top_val);
                alu_b = SPSC_AW'(r_val);
            end
            S_NXT: begin
                alu_a = SPSC_AW'(r_val);
                alu_b = SPSC_AW'(r_next);
            end
            S_CAP: begin
                alu_a = SPSC_AW'(r_cap);
                alu_b = SPSC_AW'(r_depth) + SPSC_AW'(r_diff);
            end
            default: begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    // Sequencer next-state logic
    always_comb begin
        n_state  = r_state;
        n_val    = r_val;
        n_len    = r_len;
        n_cap    = r_cap;
        n_diff   = r_diff;
        n_depth  = r_depth;
        n_next   = r_next;
        n_cnt    = r_cnt;
        n_failed = r_failed;
        n_ov     = r_ov && i_out_stall;
        n_ok     = r_ok;
        ram_we   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_val = i_pop_value;
                    // Saturate the registers into their working ranges
                    n_cap = (cap_w > MAXC) ? MAXC[SPSC_VAL_W-1:0] : i_capacity;
                    if (i_seq_length == '0) begin
                        n_len = SPSC_VAL_W'(1);
                    end else if (len_w > MAXL) begin
                        n_len = MAXL[SPSC_VAL_W-1:0];
                    end else begin
                        n_len = i_seq_length;
                    end
                    n_state = r_failed ? S_DONE : S_RNG;
                end
            end
            // Value must lie in 1..length
            S_RNG: begin
                if (r_val == '0 || alu_res.lt) begin
                    n_failed = 1'b1;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_TOP;
                end
            end
            // Compare against the top of the stack
            S_TOP: begin
                if (r_depth == '0 || alu_res.lt) begin
                    n_state = S_NXT;
                end else if (alu_res.eq) begin
                    n_depth = depth_m1;
                    n_state = S_DONE;
                end else begin
                    n_failed = 1'b1;
                    n_state  = S_DONE;
                end
            end
            // Value already pushed and gone
            S_NXT: begin
                if (alu_res.lt) begin
                    n_failed = 1'b1;
                    n_state  = S_DONE;
                end else begin
                    n_diff  = alu_res.diff[SPSC_VAL_W-1:0];
                    n_state = S_CAP;
                end
            end
            // Room check: depth + diff + 1 <= cap
            S_CAP: begin
                if (!alu_res.gt) begin
                    n_failed = 1'b1;
                    n_state  = S_DONE;
                end else if (r_diff == '0) begin
                    n_next  = NEXT_W'(r_val) + NEXT_W'(1);
                    n_state = S_DONE;
                end else begin
                    n_state = S_PUSH;
                end
            end
            // One push per cycle; the value itself is popped at once
            S_PUSH: begin
                ram_we  = 1'b1;
                n_depth = r_depth + DEPTH_W'(1);
                n_diff  = r_diff - SPSC_VAL_W'(1);
                if (r_diff == SPSC_VAL_W'(1)) begin
                    n_next  = NEXT_W'(r_val) + NEXT_W'(1);
                    n_state = S_DONE;
                end else begin
                    n_next = r_next + NEXT_W'(1);
                end
            end
            // Count the item, emit the verdict after the last one
            S_DONE: begin
                if (!last_item) begin
                    n_cnt   = r_cnt + CNT_W'(1);
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_ov     = 1'b1;
                    n_ok     = !r_failed;
                    n_cnt    = '0;
                    n_depth  = '0;
                    n_next   = NEXT_W'(1);
                    n_failed = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_depth  <= '0;
            r_next   <= NEXT_W'(1);
            r_cnt    <= '0;
            r_failed <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_depth  <= n_depth;
            r_next   <= n_next;
            r_cnt    <= n_cnt;
            r_failed <= n_failed;
            r_ov     <= n_ov;
        end
        r_val  <= n_val;
        r_len  <= n_len;
        r_cap  <= n_cap;
        r_diff <= n_diff;
        r_ok   <= n_ok;
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_ov;
    assign o_sequence_ok = r_ok;

endmodule

// File: hw/rtl/spsc_checker.sv
// Port-level assertions for the stack pop sequence checker, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module spsc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic [spsc_pkg::SPSC_VAL_W-1:0] i_pop_value,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            o_sequence_ok,
    input logic                            i_out_stall
);

    // Stalled verdict holds
    `SPSC_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sequence_ok))
    // Reset leaves no verdict pending and the input open
    `SPSC_ASSERT_ALWAYS(a_rst_clear, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall)
    // An accepted beat keeps the block busy for the next cycle
    `SPSC_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall |=> o_in_stall)
    // A verdict only appears out of a beat in progress
    `SPSC_ASSERT(a_verdict_from_work, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(o_in_stall))

endmodule

bind stack_pop_sequence_checker spsc_checker u_spsc_checker (.*);

// File: tb/pop_verdict_checker.sv
// Checker: predicts the pop-order verdicts of the stack pop sequence checker and compares them.
`timescale 1ns / 1ps
module pop_verdict_checker #(
    parameter int MAX_CAP = spsc_pkg::DEF_MAX_CAPACITY,
    parameter int MAX_LEN = spsc_pkg::DEF_MAX_LENGTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    input  logic                            pready,
    input  logic                            i_in_valid,
    input  logic [spsc_pkg::SPSC_VAL_W-1:0] i_pop_value,
    input  logic                            i_in_stall,
    input  logic                            i_out_valid,
    input  logic                            i_sequence_ok,
    input  logic                            i_out_stall,
    output int                              o_fail_count,
    output int                              o_pending
);
    import spsc_pkg::*;

    // register copies as the block sees them
    logic [SPSC_VAL_W-1:0] cap_cfg;
    logic [SPSC_VAL_W-1:0] len_cfg;

    // model stack and sequence progress
    logic [SPSC_VAL_W-1:0] stk [MAX_CAP];
    int unsigned           stk_depth;
    int unsigned           next_num;
    int unsigned           beats_seen;
    bit                    seq_bad;

    bit verdict_q [$];
    int mismatches = 0;

    function automatic void clear_sequence();
        stk_depth  = 0;
        next_num   = 1;
        beats_seen = 0;
        seq_bad    = 1'b0;
    endfunction

    // Applies one popped value to the stack; returns 1 when the order breaks.
    function automatic bit pop_breaks(input int unsigned v, input int unsigned len,
                                      input int unsigned cap);
        int unsigned top;
        int unsigned need;
        int unsigned k;
        if (v < 1 || v > len) return 1'b1;
        if (stk_depth > 0) begin
            top = stk[stk_depth-1];
            if (top > v) return 1'b1;
            if (top == v) begin
                stk_depth--;
                return 1'b0;
            end
        end
        // v already went through the stack
        if (next_num > v) return 1'b1;
        need = v - next_num + 1;
        if (stk_depth + need > cap) return 1'b1;
        // push next_num..v-1, v itself is popped straight away
        for (k = next_num; k < v; k++) begin
            stk[stk_depth] = k[SPSC_VAL_W-1:0];
            stk_depth++;
        end
        next_num = v + 1;
        return 1'b0;
    endfunction

    // One accepted beat: update the sequence, queue a verdict at its end.
    function automatic void judge_pop(input logic [SPSC_VAL_W-1:0] v);
        int unsigned len;
        int unsigned cap;
        len = len_cfg;
        cap = cap_cfg;
        if (len == 0) len = 1;
        if (len > MAX_LEN) len = MAX_LEN;
        if (cap > MAX_CAP) cap = MAX_CAP;
        if (!seq_bad) seq_bad = pop_breaks(v, len, cap);
        beats_seen++;
        if (beats_seen >= len) begin
            verdict_q.push_back(!seq_bad);
            clear_sequence();
        end
    endfunction

    function automatic void log_mismatch(input string msg);
        if (mismatches < 10) $display("%0t ns: %s", $time, msg);
        mismatches++;
    endfunction

    // watch register writes and both channels
    always @(posedge i_clk) begin : watch
        bit exp_ok;
        if (!i_rst_n) begin
            cap_cfg = CAPACITY_RST;
            len_cfg = SEQ_LENGTH_RST;
            clear_sequence();
            verdict_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_CAPACITY) cap_cfg = pwdata[SPSC_VAL_W-1:0];
                else                          len_cfg = pwdata[SPSC_VAL_W-1:0];
            end
            if (i_in_valid && !i_in_stall) judge_pop(i_pop_value);
            if (i_out_valid && !i_out_stall) begin
                if (verdict_q.size() == 0) begin
                    log_mismatch($sformatf("verdict %0d with none expected", i_sequence_ok));
                end else begin
                    exp_ok = verdict_q.pop_front();
                    if (i_sequence_ok !== exp_ok)
                        log_mismatch($sformatf("verdict mismatch: expected %0d, got %0d",
                                               exp_ok, i_sequence_ok));
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= verdict_q.size();
    end

endmodule

// File: tb/stack_pop_sequence_checker_test.sv
// Testbench top: drives pop sequences and register settings into the stack pop sequence checker.
`timescale 1ns / 1ps
module stack_pop_sequence_checker_test;
    import spsc_pkg::*;

    // longest time one beat may still be in flight after its verdict
    localparam int DRAIN_CYCLES = 1100;
    localparam int HOLD_CYCLES  = 400;

    typedef enum int {RX_OPEN, RX_HALF, RX_HEAVY, RX_TOGGLE} t_rx_mode;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [2:0]            paddr       = '0;
    logic [31:0]           pwdata      = '0;
    wire  [31:0]           prdata;
    wire                   pready;
    logic                  i_in_valid  = 1'b0;
    logic [SPSC_VAL_W-1:0] i_pop_value = '0;
    wire                   o_in_stall;
    wire                   o_out_valid;
    wire                   o_sequence_ok;
    logic                  i_out_stall = 1'b0;

    int fail_count;
    int pending;
    bit hold_req   = 1'b0;
    int burst_left = 0;

    logic [SPSC_VAL_W-1:0] pop_plan [$];

    always #10 i_clk = ~i_clk;

    stack_pop_sequence_checker i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .i_pop_value   (i_pop_value),
        .o_in_stall    (o_in_stall),
        .o_out_valid   (o_out_valid),
        .o_sequence_ok (o_sequence_ok),
        .i_out_stall   (i_out_stall)
    );

    pop_verdict_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .i_pop_value   (i_pop_value),
        .i_in_stall    (o_in_stall),
        .i_out_valid   (o_out_valid),
        .i_sequence_ok (o_sequence_ok),
        .i_out_stall   (i_out_stall),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // register write: setup cycle, then access cycle until pready
    task automatic write_reg(input logic idx, input logic [SPSC_VAL_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one beat on the input channel; bursts of random length, random gaps
    task automatic offer_value(input logic [SPSC_VAL_W-1:0] v);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_in_valid  <= 1'b1;
        i_pop_value <= v;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        burst_left--;
    endtask

    task automatic play_plan();
        foreach (pop_plan[i]) offer_value(pop_plan[i]);
        pop_plan.delete();
    endtask

    // stop sending, wait for every verdict, then let the block go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // random legal pop order of 1..len through a stack of at most cap values
    function automatic void build_pop_order(input int len, input int cap);
        logic [SPSC_VAL_W-1:0] held [$];
        int next_num;
        next_num = 1;
        pop_plan.delete();
        while (pop_plan.size() < len) begin
            if (held.size() > 0 &&
                (next_num > len || held.size() >= cap || $urandom_range(0, 1) == 1)) begin
                pop_plan.push_back(held.pop_back());
            end else begin
                held.push_back(next_num[SPSC_VAL_W-1:0]);
                next_num++;
            end
        end
    endfunction

    // break a legal order: wild value, repeated value or swapped pair
    function automatic void spoil_pop_order(input int len);
        int a;
        int b;
        logic [SPSC_VAL_W-1:0] tmp;
        a = $urandom_range(0, len - 1);
        b = $urandom_range(0, len - 1);
        if ($urandom_range(0, 2) == 0) begin
            pop_plan[a] = SPSC_VAL_W'($urandom_range(0, 2047));
        end else if ($urandom_range(0, 1) == 0) begin
            pop_plan[a] = pop_plan[b];
        end else begin
            tmp         = pop_plan[a];
            pop_plan[a] = pop_plan[b];
            pop_plan[b] = tmp;
        end
    endfunction

    // output side: stall patterns of its own, plus a long hold on request
    initial begin : receiver
        t_rx_mode mode;
        int       mode_left;
        mode      = RX_OPEN;
        mode_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(32, 256);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:   i_out_stall <= 1'b0;
                    RX_HALF:   i_out_stall <= ($urandom_range(0, 1) == 0);
                    RX_HEAVY:  i_out_stall <= ($urandom_range(0, 3) != 0);
                    default:   i_out_stall <= mode_left[2];
                endcase
            end
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        int unsigned cap_set [7];
        int unsigned len_set [7];
        int          seq_set [7];
        int          cap_eff;
        int          len_eff;

        cap_set = '{2047, 0, 1, 3, 4, 2, 1024};
        len_set = '{9, 3, 1, 0, 6, 5, 2047};
        seq_set = '{12, 10, 60, 30, 25, 20, 1};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings (capacity 5, length 7): full descent overflows the stack
        pop_plan = '{7, 6, 5, 4, 3, 2, 1};
        play_plan();
        // length changed in the middle of a sequence
        pop_plan = '{2, 1};
        play_plan();
        settle();
        write_reg(REG_SEQ_LENGTH, SPSC_VAL_W'(3));
        pop_plan = '{3};
        play_plan();
        // zero value, values above the length, top above value, value popped twice
        pop_plan = '{0, 1, 2, 2047, 1024, 3, 3, 1, 2, 1, 1, 2};
        play_plan();
        settle();

        // random phases over capacity and length settings, extremes included
        for (int ph = 0; ph < 7; ph++) begin
            write_reg(REG_CAPACITY, SPSC_VAL_W'(cap_set[ph]));
            write_reg(REG_SEQ_LENGTH, SPSC_VAL_W'(len_set[ph]));
            cap_eff = (cap_set[ph] > DEF_MAX_CAPACITY) ? DEF_MAX_CAPACITY : cap_set[ph];
            len_eff = (len_set[ph] == 0) ? 1 :
                      (len_set[ph] > DEF_MAX_LENGTH) ? DEF_MAX_LENGTH : len_set[ph];
            // one verdict per beat here, so a long hold backs up the input
            if (len_eff == 1 && cap_eff == 1) hold_req = 1'b1;
            repeat (seq_set[ph]) begin
                build_pop_order(len_eff, cap_eff);
                if (len_eff <= 64 && $urandom_range(0, 9) < 3) spoil_pop_order(len_eff);
                play_plan();
            end
            settle();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin : watchdog
        #8_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: stack_pop_sequence_checker.f
+incdir+hw/rtl
hw/rtl/spsc_pkg.sv
hw/rtl/spsc_ram.sv
hw/rtl/spsc_alu.sv
hw/rtl/spsc_core.sv
hw/rtl/stack_pop_sequence_checker.sv
hw/rtl/spsc_checker.sv
tb/pop_verdict_checker.sv
tb/stack_pop_sequence_checker_test.sv
